// ----- hdl/sha256_hash_engine_unit_assert.svh -----
// ---------------------------------------------------------------------------
// SHA-256 hash engine assertion macros
// Shorthand for the concurrent checks written at the end of the top level.
// ---------------------------------------------------------------------------
`ifndef SHA256_HASH_ENGINE_UNIT_ASSERT_SVH
`define SHA256_HASH_ENGINE_UNIT_ASSERT_SVH

// Same-cycle implication, checked outside reset
`define SHA256_ASSERT_IMP(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset
`define SHA256_ASSERT_NXT(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hdl/sha256_pkg.sv -----
// ---------------------------------------------------------------------------
// SHA-256 hash engine package
// Item types, block queue control structs, hash constants and sigma functions.
// ---------------------------------------------------------------------------
`default_nettype none

package sha256_pkg;

	// Default number of 512-bit blocks buffered between packer and core
	localparam int unsigned BLKQ_DEPTH = 2;

	// Padding constants
	localparam logic [7:0] PAD_BYTE = 8'h80;
	localparam logic [5:0] LEN_POS  = 6'd56;
	localparam logic [5:0] BLK_LAST = 6'd63;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       final_byte;
	} in_item_t;

	typedef struct packed {
		logic [31:0] digest_word;
		logic [2:0]  word_number;
		logic        last_word;
	} out_item_t;

	// Packer to block queue: one byte write, optional block push
	typedef struct packed {
		logic       en;
		logic [3:0] word;
		logic [1:0] lane;
		logic [7:0] data;
		logic       push;
		logic       last;
	} blkq_wr_t;

	// Core to block queue: word read address and block release
	typedef struct packed {
		logic [3:0] rd_word;
		logic       pop;
	} blkq_rd_t;

	// Block queue status
	typedef struct packed {
		logic room;
		logic avail;
		logic head_last;
	} blkq_stat_t;

	localparam logic [31:0] IV [8] = '{
		32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
		32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19
	};

	localparam logic [31:0] K_TAB [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	function automatic logic [31:0] big_sig0(input logic [31:0] x);
		return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
	endfunction

	function automatic logic [31:0] big_sig1(input logic [31:0] x);
		return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
	endfunction

	function automatic logic [31:0] sml_sig0(input logic [31:0] x);
		return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
	endfunction

	function automatic logic [31:0] sml_sig1(input logic [31:0] x);
		return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
	endfunction

endpackage

`default_nettype wire

// ----- hdl/sha256_hash_engine_unit.sv -----
// ---------------------------------------------------------------------------
// SHA-256 hash engine
// Message bytes go in one per push, the last one flagged with final_byte;
// eight digest words come out, word_number 0 first, last_word on the eighth.
// Bytes are taken one per cycle while the block queue (BLK_DEPTH blocks,
// default 2) has a free entry. The core compresses each 64-byte block in a
// start step, 64 rounds at one round per cycle and a chain update, held on a
// message's last block until the digest buffer is free; the rounds set the
// sustained rate. After the final byte the packer writes the padding one
// byte a cycle while the queue has room, up to the end of the block, plus
// a whole extra block when fewer than nine bytes remain, and takes no new
// byte meanwhile. The digest is ready after its last chain update and drains
// as eight items; the next message may be packed and compressed meanwhile.
// ---------------------------------------------------------------------------
`default_nettype none

`include "sha256_hash_engine_unit_assert.svh"

module sha256_hash_engine_unit import sha256_pkg::*; #(
	parameter int unsigned BLK_DEPTH = BLKQ_DEPTH
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     push,
	output logic          full,
	input  wire in_item_t item,
	output logic          empty,
	input  wire logic     pop,
	output out_item_t     result
);

	blkq_wr_t    qwr;
	blkq_rd_t    qrd;
	blkq_stat_t  qstat;
	logic [31:0] rd_data;

	sha256_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (full),
		.item   (item),
		.qstat  (qstat),
		.qwr    (qwr)
	);

	sha256_blkq #(
		.DEPTH (BLK_DEPTH)
	) u_blkq (
		.clk     (clk),
		.arst_n  (arst_n),
		.qwr     (qwr),
		.qrd     (qrd),
		.qstat   (qstat),
		.rd_data (rd_data)
	);

	sha256_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.qstat   (qstat),
		.rd_data (rd_data),
		.qrd     (qrd),
		.empty   (empty),
		.pop     (pop),
		.result  (result)
	);

	// Byte writes only into a free queue entry
	`SHA256_ASSERT_IMP(a_push_room, clk, arst_n, qwr.en, qstat.room, "block queue written while full")
	// Core releases only a block that is present
	`SHA256_ASSERT_IMP(a_pop_avail, clk, arst_n, qrd.pop, qstat.avail, "block queue popped while empty")
	// Digest buffer drains after its eighth word
	`SHA256_ASSERT_NXT(a_dig_drain, clk, arst_n, pop && !empty && result.last_word, empty, "digest still pending after last word")

endmodule

`default_nettype wire

// ----- hdl/sha256_front.sv -----
// ---------------------------------------------------------------------------
// SHA-256 byte packer and padder
// Writes message bytes into the free block-queue entry, then pads the tail
// with the marker byte, zeros and the 64-bit bit length, one byte a cycle.
// ---------------------------------------------------------------------------
`default_nettype none

module sha256_front import sha256_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       push,
	output logic            full,
	input  wire in_item_t   item,
	input  wire blkq_stat_t qstat,
	output blkq_wr_t        qwr
);

	localparam logic F_FILL = 1'b0;
	localparam logic F_PAD  = 1'b1;

	logic        state_q;
	logic [5:0]  pos_q;
	logic [60:0] count_q;
	logic [63:0] len_q;
	logic        pad_first_q;
	logic        len_ok_q;

	logic        in_fill;
	logic        accept;
	logic        pad_go;
	logic        pos_end;
	logic        len_ok_now;
	logic [2:0]  len_idx;
	logic [7:0]  len_byte;
	logic [7:0]  pad_byte;
	logic [60:0] cnt_next;

	// Classify the current cycle
	assign in_fill  = (state_q == F_FILL);
	assign accept   = push && in_fill && qstat.room;
	assign full     = !(in_fill && qstat.room);
	assign pad_go   = (state_q == F_PAD) && qstat.room;
	assign pos_end  = (pos_q == BLK_LAST);
	assign cnt_next = count_q + 61'd1;

	// Length goes in this block once the marker sits before the length field
	assign len_ok_now = pad_first_q ? (pos_q < LEN_POS) : len_ok_q;
	assign len_idx    = 3'd7 - pos_q[2:0];
	assign len_byte   = len_q[{len_idx, 3'b000} +: 8];

	always_comb begin
		if (pad_first_q) begin
			pad_byte = PAD_BYTE;
		end else if (len_ok_now && (pos_q >= LEN_POS)) begin
			pad_byte = len_byte;
		end else begin
			pad_byte = 8'h00;
		end
	end

	// Drive the byte write into the queue tail entry
	always_comb begin
		qwr.en   = accept || pad_go;
		qwr.word = pos_q[5:2];
		qwr.lane = pos_q[1:0];
		qwr.data = in_fill ? item.data_byte : pad_byte;
		qwr.push = (accept || pad_go) && pos_end;
		qwr.last = !in_fill && len_ok_now;
	end

	// Advance position, count and pad sequence
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= F_FILL;
			pos_q       <= '0;
			count_q     <= '0;
			pad_first_q <= 1'b0;
			len_ok_q    <= 1'b0;
		end else if (accept) begin
			pos_q   <= pos_q + 6'd1;
			count_q <= cnt_next;
			if (item.final_byte) begin
				state_q     <= F_PAD;
				pad_first_q <= 1'b1;
			end
		end else if (pad_go) begin
			pos_q       <= pos_q + 6'd1;
			pad_first_q <= 1'b0;
			if (pos_end) begin
				if (len_ok_now) begin
					state_q <= F_FILL;
					count_q <= '0;
				end else begin
					len_ok_q <= 1'b1;
				end
			end else if (pad_first_q) begin
				len_ok_q <= (pos_q < LEN_POS);
			end
		end
	end

	// Latch the message bit length on the final byte
	always_ff @(posedge clk) begin
		if (accept && item.final_byte) begin
			len_q <= {cnt_next, 3'b000};
		end
	end

endmodule

`default_nettype wire

// ----- hdl/sha256_blkq.sv -----
// ---------------------------------------------------------------------------
// SHA-256 block queue
// Holds whole 512-bit blocks between packer and core; byte-wide writes at
// the tail entry, registered word reads from the head entry.
// ---------------------------------------------------------------------------
`default_nettype none

module sha256_blkq import sha256_pkg::*; #(
	parameter int unsigned DEPTH = BLKQ_DEPTH
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire blkq_wr_t   qwr,
	input  wire blkq_rd_t   qrd,
	output blkq_stat_t      qstat,
	output logic [31:0]     rd_data
);

	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam int unsigned AW = PW + 4;

	logic [31:0]     mem [DEPTH*16];
	logic [DEPTH-1:0] last_q;
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [CW-1:0]   cnt_q;

	logic [AW-1:0]   waddr;
	logic [AW-1:0]   raddr;

	assign waddr = {wr_ptr_q, qwr.word};
	assign raddr = {rd_ptr_q, qrd.rd_word};

	always_comb begin
		qstat.room      = (cnt_q < CW'(DEPTH));
		qstat.avail     = (cnt_q != '0);
		qstat.head_last = last_q[rd_ptr_q];
	end

	// Byte write into the tail entry, registered word read from the head
	always_ff @(posedge clk) begin
		if (qwr.en) begin
			mem[waddr][{~qwr.lane, 3'b000} +: 8] <= qwr.data;
		end
		if (qwr.push) begin
			last_q[wr_ptr_q] <= qwr.last;
		end
		rd_data <= mem[raddr];
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (qwr.push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (qrd.pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (qwr.push && !qrd.pop) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (qrd.pop && !qwr.push) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

endmodule

`default_nettype wire

// ----- hdl/sha256_back.sv -----
// ---------------------------------------------------------------------------
// SHA-256 compression core and digest buffer
// Runs 64 rounds over the head block, one round a cycle, updates the chain
// value and presents the digest of each finished message as eight items.
// ---------------------------------------------------------------------------
`default_nettype none

module sha256_back import sha256_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire blkq_stat_t  qstat,
	input  wire logic [31:0] rd_data,
	output blkq_rd_t         qrd,
	output logic             empty,
	input  wire logic        pop,
	output out_item_t        result
);

	localparam logic [1:0] B_IDLE  = 2'd0;
	localparam logic [1:0] B_ROUND = 2'd1;
	localparam logic [1:0] B_FINAL = 2'd2;

	logic [1:0]  state_q;
	logic [5:0]  t_q;
	logic        last_blk_q;
	logic [31:0] chain_q [8];
	logic [31:0] work_q [8];
	logic [31:0] win_q [15];
	logic [31:0] wsch_q;
	logic [31:0] dig_q [8];
	logic        dig_valid_q;
	logic [2:0]  rd_idx_q;

	logic [31:0] w_cur;
	logic [31:0] t1;
	logic [31:0] t2;
	logic [31:0] ch;
	logic [31:0] maj;
	logic [31:0] w_next;
	logic [31:0] new_chain [8];
	logic        start;
	logic        finish;
	logic        out_pop;

	// Round inputs: block words for the first sixteen rounds, then schedule
	assign w_cur  = (t_q[5:4] == 2'd0) ? rd_data : wsch_q;
	assign ch     = (work_q[4] & work_q[5]) ^ (~work_q[4] & work_q[6]);
	assign maj    = (work_q[0] & work_q[1]) ^ (work_q[0] & work_q[2]) ^
	                (work_q[1] & work_q[2]);
	assign t1     = work_q[7] + big_sig1(work_q[4]) + ch + K_TAB[t_q] + w_cur;
	assign t2     = big_sig0(work_q[0]) + maj;
	assign w_next = sml_sig1(win_q[0]) + win_q[5] + sml_sig0(win_q[13]) + win_q[14];

	always_comb begin
		for (int i = 0; i < 8; i++) begin
			new_chain[i] = chain_q[i] + work_q[i];
		end
	end

	// Start on a waiting block; last blocks wait for a free digest buffer
	assign start   = (state_q == B_IDLE) && qstat.avail;
	assign finish  = (state_q == B_FINAL) && (!last_blk_q || !dig_valid_q);
	assign out_pop = pop && dig_valid_q;

	always_comb begin
		qrd.pop     = finish;
		qrd.rd_word = (state_q == B_ROUND) ? (t_q[3:0] + 4'd1) : 4'd0;
	end

	// Sequence rounds, chain update and digest hand-off
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			t_q         <= '0;
			dig_valid_q <= 1'b0;
			rd_idx_q    <= '0;
			for (int i = 0; i < 8; i++) begin
				chain_q[i] <= IV[i];
			end
		end else begin
			case (state_q)
				B_IDLE: begin
					if (start) begin
						state_q <= B_ROUND;
						t_q     <= '0;
					end
				end
				B_ROUND: begin
					t_q <= t_q + 6'd1;
					if (t_q == 6'd63) begin
						state_q <= B_FINAL;
					end
				end
				B_FINAL: begin
					if (finish) begin
						state_q <= B_IDLE;
						for (int i = 0; i < 8; i++) begin
							chain_q[i] <= last_blk_q ? IV[i] : new_chain[i];
						end
					end
				end
				default: begin
					state_q <= B_IDLE;
				end
			endcase

			// Drain the digest one word per pop
			if (finish && last_blk_q) begin
				dig_valid_q <= 1'b1;
				rd_idx_q    <= '0;
			end else if (out_pop) begin
				rd_idx_q <= rd_idx_q + 3'd1;
				if (rd_idx_q == 3'd7) begin
					dig_valid_q <= 1'b0;
				end
			end
		end
	end

	// Working registers, schedule window and digest words
	always_ff @(posedge clk) begin
		if (start) begin
			last_blk_q <= qstat.head_last;
			for (int i = 0; i < 8; i++) begin
				work_q[i] <= chain_q[i];
			end
		end else if (state_q == B_ROUND) begin
			work_q[0] <= t1 + t2;
			work_q[1] <= work_q[0];
			work_q[2] <= work_q[1];
			work_q[3] <= work_q[2];
			work_q[4] <= work_q[3] + t1;
			work_q[5] <= work_q[4];
			work_q[6] <= work_q[5];
			work_q[7] <= work_q[6];
			win_q[0]  <= w_cur;
			for (int i = 1; i < 15; i++) begin
				win_q[i] <= win_q[i-1];
			end
			wsch_q <= w_next;
		end
		if (finish && last_blk_q) begin
			for (int i = 0; i < 8; i++) begin
				dig_q[i] <= new_chain[i];
			end
		end
	end

	always_comb begin
		empty              = !dig_valid_q;
		result.digest_word = dig_q[rd_idx_q];
		result.word_number = rd_idx_q;
		result.last_word   = (rd_idx_q == 3'd7);
	end

endmodule

`default_nettype wire

// ----- test/sha256_digest_checker.sv -----
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// SHA-256 digest checker
// Watches the byte and digest channels of the hash engine. Every accepted
// byte is fed into a local SHA-256 predictor. On a final byte, the eight
// digest words it predicts are queued. Every accepted digest item is
// compared field by field with the oldest queued word.
// ---------------------------------------------------------------------------
module sha256_digest_checker import sha256_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  logic      full,
	input  in_item_t  item,
	input  logic      empty,
	input  logic      pop,
	input  out_item_t result,
	output int        pending,
	output int        errors
);

	localparam logic [7:0] MARK_BYTE = 8'h80;
	localparam int         LEN_OFFSET = 56;

	localparam logic [31:0] INIT_HASH [8] = '{
		32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
		32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19
	};

	localparam logic [31:0] ROUND_K [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	// Predictor state: chaining value, current block, message length
	logic [31:0] chain [8];
	logic [7:0]  block_bytes [64];
	logic [60:0] msg_len;
	out_item_t   digest_q [$];
	out_item_t   want;
	int          fail_count;

	function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
		return (x >> n) | (x << (32 - n));
	endfunction

	// Start a new message from the initial hash value
	function automatic void start_message();
		for (int i = 0; i < 8; i++)
			chain[i] = INIT_HASH[i];
		msg_len = '0;
	endfunction

	// Run the 64-round compression over the current block
	function automatic void compress_block();
		logic [31:0] w [64];
		logic [31:0] v [8];
		logic [31:0] s0, s1, t1, t2;
		for (int i = 0; i < 16; i++)
			w[i] = {block_bytes[4*i], block_bytes[4*i+1],
				block_bytes[4*i+2], block_bytes[4*i+3]};
		for (int t = 16; t < 64; t++) begin
			s0 = rotr(w[t-15], 7) ^ rotr(w[t-15], 18) ^ (w[t-15] >> 3);
			s1 = rotr(w[t-2], 17) ^ rotr(w[t-2], 19) ^ (w[t-2] >> 10);
			w[t] = w[t-16] + s0 + w[t-7] + s1;
		end
		for (int i = 0; i < 8; i++)
			v[i] = chain[i];
		for (int t = 0; t < 64; t++) begin
			t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
				+ ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_K[t] + w[t];
			t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
				+ ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
			v[7] = v[6];
			v[6] = v[5];
			v[5] = v[4];
			v[4] = v[3] + t1;
			v[3] = v[2];
			v[2] = v[1];
			v[1] = v[0];
			v[0] = t1 + t2;
		end
		for (int i = 0; i < 8; i++)
			chain[i] = chain[i] + v[i];
	endfunction

	// Absorb one byte; on the final byte pad, finish and queue the digest
	function automatic void absorb_byte(input in_item_t it);
		logic [63:0] bit_len;
		out_item_t   word;
		block_bytes[msg_len[5:0]] = it.data_byte;
		msg_len = msg_len + 61'd1;
		if (!it.final_byte) begin
			if (msg_len[5:0] == 6'd0)
				compress_block();
		end else begin
			bit_len = {msg_len, 3'b000};
			// final byte closed a block exactly: compress it first
			if (msg_len[5:0] == 6'd0)
				compress_block();
			block_bytes[msg_len[5:0]] = MARK_BYTE;
			for (int p = msg_len[5:0] + 1; p < 64; p++)
				block_bytes[p] = 8'h00;
			// no room for the length: spill it into an extra zero block
			if (msg_len[5:0] >= LEN_OFFSET) begin
				compress_block();
				for (int p = 0; p < LEN_OFFSET; p++)
					block_bytes[p] = 8'h00;
			end
			for (int i = 0; i < 8; i++)
				block_bytes[LEN_OFFSET + i] = bit_len[63 - 8*i -: 8];
			compress_block();
			for (int i = 0; i < 8; i++) begin
				word.digest_word = chain[i];
				word.word_number = 3'(i);
				word.last_word   = (i == 7);
				digest_q = {digest_q, word};
			end
			start_message();
		end
	endfunction

	// Compare digest items, then absorb accepted bytes
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_message();
			digest_q.delete();
			fail_count = 0;
			pending <= 0;
			errors <= 0;
		end else begin
			if (pop && !empty) begin
				if (digest_q.size() == 0) begin
					$error("unexpected digest item: digest_word %h word_number %0d last_word %b",
						result.digest_word, result.word_number, result.last_word);
					fail_count++;
				end else begin
					want = digest_q.pop_front();
					if (result.digest_word !== want.digest_word) begin
						$error("digest_word: expected %h, actual %h",
							want.digest_word, result.digest_word);
						fail_count++;
					end
					if (result.word_number !== want.word_number) begin
						$error("word_number: expected %0d, actual %0d",
							want.word_number, result.word_number);
						fail_count++;
					end
					if (result.last_word !== want.last_word) begin
						$error("last_word: expected %b, actual %b",
							want.last_word, result.last_word);
						fail_count++;
					end
				end
			end
			if (push && !full)
				absorb_byte(item);
			pending <= digest_q.size();
			errors <= fail_count;
		end
	end

endmodule

// ----- test/tb_top.sv -----
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// SHA-256 hash engine testbench
// Sends a few fixed messages, then one random message long enough to push
// the length into an extra block or to fill a block exactly, then short
// random messages in three phases. Sender and receiver stall at random in
// the first two; a checker predicts every digest.
// ---------------------------------------------------------------------------
module tb_top;
	import sha256_pkg::*;

	localparam int LIMIT      = 200000;
	localparam int TAIL_WAIT  = 200;
	localparam int PHASE_MIN_BYTES = 12;
	localparam int PHASE_MIN_MSGS  = 3;

	logic      clk;
	logic      arst_n;
	logic      push;
	logic      full;
	in_item_t  item;
	logic      empty;
	logic      pop;
	out_item_t result;

	int send_idle;
	int take_idle;
	int pending;
	int errors;
	int cycles;

	sha256_hash_engine_unit dut (
		.clk,
		.arst_n,
		.push,
		.full,
		.item,
		.empty,
		.pop,
		.result
	);

	sha256_digest_checker digest_chk (
		.clk,
		.arst_n,
		.push,
		.full,
		.item,
		.empty,
		.pop,
		.result,
		.pending,
		.errors
	);

	// 10 ns clock
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Drain digest items, stalling at random
	always @(posedge clk) begin
		if (!arst_n)
			pop <= 1'b0;
		else
			pop <= ($urandom_range(99) >= take_idle);
	end

	// Send one byte item, idling at random before it; return once accepted
	task automatic send_byte(input logic [7:0] data, input logic fin);
		while ($urandom_range(99) < send_idle) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push <= 1'b1;
		item <= '{data_byte: data, final_byte: fin};
		@(posedge clk);
		while (full)
			@(posedge clk);
	endtask

	// Hold off the sender until every queued digest has come out
	task automatic wait_drained();
		push <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	// Stop a hung run
	initial begin
		cycles = 0;
		while (cycles < LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("tb_top: FAIL");
		$finish;
	end

	// Stimulus and verdict
	initial begin
		int len;
		int msg_count;
		int phase_bytes;
		int phase_msgs;
		arst_n = 1'b0;
		push = 1'b0;
		item = '0;
		send_idle = 0;
		take_idle = 0;
		msg_count = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// fixed messages: "abc", single zero byte, single all-ones byte
		send_byte(8'h61, 1'b0);
		send_byte(8'h62, 1'b0);
		send_byte(8'h63, 1'b1);
		send_byte(8'h00, 1'b1);
		send_byte(8'hFF, 1'b1);
		// alternating all-ones and zero bytes back to back
		for (int i = 0; i < 8; i++)
			send_byte((i % 2) ? 8'h00 : 8'hFF, i == 7);
		wait_drained();

		// random messages in three phases, the last one without stalls
		for (int ph = 0; ph < 3; ph++) begin
			send_idle = (ph == 0) ? 38 : (ph == 1) ? 78 : 0;
			take_idle = (ph == 0) ? 78 : (ph == 1) ? 38 : 0;
			phase_bytes = 0;
			phase_msgs = 0;
			while (phase_bytes < PHASE_MIN_BYTES || phase_msgs < PHASE_MIN_MSGS) begin
				// marker lands too late for the length field, or the
				// message fills a whole block exactly
				if (msg_count == 0)
					len = $urandom_range(56, 64);
				else
					len = $urandom_range(1, 8);
				for (int i = 0; i < len; i++)
					send_byte(8'($urandom_range(255)), i == len - 1);
				phase_bytes += len;
				phase_msgs++;
				msg_count++;
			end
		end

		wait_drained();
		repeat (TAIL_WAIT) @(posedge clk);
		if (errors == 0 && pending == 0)
			$display("tb_top: PASS");
		else
			$display("tb_top: FAIL");
		$finish;
	end

endmodule
